// ----- src/blob_bounding_box_finder_defines.svh -----
// Assertion macros shared by the blob finder RTL.
// No dependencies.
`ifndef BLOB_BOUNDING_BOX_FINDER_DEFINES_SVH
`define BLOB_BOUNDING_BOX_FINDER_DEFINES_SVH
`define BBF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("violated: lbl");
`define BBF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("violated: lbl");
`endif

// ----- src/bbf_pkg.sv -----
// Shared types and constants of the blob bounding box finder.
// No dependencies.
`timescale 1ns / 1ps
package bbf_pkg;
  localparam int PROB_W = 16;
  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MIN_AREA   = 2'd3;

  typedef struct packed {
    logic [15:0] pixel_prob;
    logic        frame_end;
  } pix_t;

  typedef struct packed {
    logic        box_valid;
    logic [7:0]  left_col;
    logic [7:0]  top_row;
    logic [8:0]  box_width;
    logic [8:0]  box_height;
    logic [15:0] mean_prob;
    logic        dropped;
    logic        last_result;
  } res_t;

  // Command from the labeling engine to the box emitter.
  typedef struct packed {
    logic        is_end;
    logic        dropped;
    logic [7:0]  left_col;
    logic [7:0]  top_row;
    logic [8:0]  box_width;
    logic [8:0]  box_height;
    logic [31:0] prob_sum;
    logic [16:0] pixel_count;
  } cmd_t;
endpackage

// ----- src/bbf_stream_if.sv -----
// Valid/ready stream interface carrying one payload type.
// No dependencies.
`timescale 1ns / 1ps
interface bbf_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bbf_cmd_fifo.sv -----
// Short queue between labeling engine and emitter.
// Depends on bbf_pkg.
`timescale 1ns / 1ps
module bbf_cmd_fifo import bbf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);
  cmd_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (pop && !empty) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ----- src/bbf_emitter.sv -----
// Back end: divides sum by count (restoring, one bit a cycle), formats results.
// Depends on bbf_pkg and bbf_stream_if.
`timescale 1ns / 1ps
`include "blob_bounding_box_finder_defines.svh"
module bbf_emitter import bbf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  bbf_stream_if.source res_out
);
  typedef enum logic [1:0] {E_IDLE, E_DIV, E_OUT} est_t;
  est_t        state;
  cmd_t        cur;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [5:0]  bit_cnt;
  logic [17:0] trial;

  assign cmd_pop = (state == E_IDLE) && !cmd_empty;
  assign trial   = {rem, quo[31]} - {1'b0, cur.pixel_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= E_IDLE;
      res_out.valid <= 1'b0;
    end else begin
      unique case (state)
        E_IDLE: if (!cmd_empty) begin
          cur     <= cmd;
          quo     <= cmd.prob_sum;
          rem     <= '0;
          bit_cnt <= 6'd32;
          state   <= cmd.is_end ? E_OUT : E_DIV;
          if (cmd.is_end) begin
            res_out.valid <= 1'b1;
            res_out.data  <= '{box_valid: 1'b0, left_col: '0, top_row: '0,
                               box_width: '0, box_height: '0, mean_prob: '0,
                               dropped: cmd.dropped, last_result: 1'b1};
          end
        end
        E_DIV: begin
          if (!trial[17]) begin
            rem <= trial[16:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[15:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          bit_cnt <= bit_cnt - 6'd1;
          if (bit_cnt == 6'd1) begin
            state         <= E_OUT;
            res_out.valid <= 1'b1;
            res_out.data  <= '{box_valid: 1'b1, left_col: cur.left_col,
                               top_row: cur.top_row, box_width: cur.box_width,
                               box_height: cur.box_height,
                               mean_prob: (!trial[17]) ? {quo[14:0], 1'b1}
                                                       : {quo[14:0], 1'b0},
                               dropped: 1'b0, last_result: 1'b0};
          end
        end
        E_OUT: if (res_out.ready) begin
          res_out.valid <= 1'b0;
          state         <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  `BBF_ASSERT_IMPL(a_valid_in_out, clk, rst, res_out.valid, state == E_OUT)
  `BBF_ASSERT_IMPL(a_pop_idle, clk, rst, cmd_pop, state == E_IDLE)
  `BBF_ASSERT_NEXT(a_div_len, clk, rst, state == E_IDLE && cmd_pop && !cmd.is_end,
                   state == E_DIV && bit_cnt == 6'd32)
endmodule

// ----- src/bbf_labeler.sv -----
// Front end: loads pixels, scans, flood fills, pushes commands to the queue.
// Depends on bbf_pkg and bbf_stream_if.
`timescale 1ns / 1ps
`include "blob_bounding_box_finder_defines.svh"
module bbf_labeler import bbf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BOXES  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] threshold,
  input  logic [8:0]  map_width,
  input  logic [8:0]  map_height,
  input  logic [16:0] min_area,
  bbf_stream_if.sink  pix_in,
  output logic        push,
  output cmd_t        push_data,
  input  logic        full
);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW    = AW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_SCAN_RD, S_SCAN_CHK, S_POP, S_POP_WAIT, S_NB_RD, S_NB_CHK,
    S_DONE, S_PUSH, S_END
  } st_t;

  // Pixel store is linear in raster order; visited map and queue use {y, x}.
  logic [15:0]   prob_mem [CELLS];
  logic          vis_mem  [2**AW];
  logic [AW-1:0] queue_mem [CELLS];

  st_t           state;
  logic [CW-1:0] load_pos;
  logic [AW-1:0] clr_addr;
  logic [XW:0]   w;
  logic [YW:0]   h;
  logic [XW-1:0] sx, cx;
  logic [YW-1:0] sy, cy;
  logic [CW-1:0] q_head, q_tail;
  logic [XW-1:0] left_b, right_b;
  logic [YW-1:0] top_b, bot_b;
  logic [31:0]   sum;
  logic [16:0]   cnt;
  logic [5:0]    sent;
  logic          ovf;
  logic [1:0]    nb;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          nb_ok;
  logic [XW-1:0] rd_x;
  logic [YW-1:0] rd_y;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   p_lin;
  logic [15:0]   rd_prob;
  logic          rd_vis;
  logic [AW-1:0] q_rd;
  logic          vis_we;
  logic [AW-1:0] vis_wa;
  logic          vis_wd;
  logic [XW:0]   mw_c;
  logic [YW:0]   mh_c;

  always_comb begin
    mw_c = (map_width == 9'd0) ? (XW+1)'(1) :
           ({23'd0, map_width} > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(map_width);
    mh_c = (map_height == 9'd0) ? (YW+1)'(1) :
           ({23'd0, map_height} > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(map_height);
  end

  // Neighbor coordinates: right, left, down, up.
  always_comb begin
    nx = cx;
    ny = cy;
    nb_ok = 1'b0;
    unique case (nb)
      2'd0: begin nx = cx + XW'(1); nb_ok = ({1'b0, cx} + (XW+1)'(1)) < w; end
      2'd1: begin nx = cx - XW'(1); nb_ok = cx != '0; end
      2'd2: begin ny = cy + YW'(1); nb_ok = ({1'b0, cy} + (YW+1)'(1)) < h; end
      2'd3: begin ny = cy - YW'(1); nb_ok = cy != '0; end
      default: ;
    endcase
  end

  always_comb begin
    rd_x = nx;
    rd_y = ny;
    if (state == S_SCAN_RD) begin
      rd_x = sx;
      rd_y = sy;
    end
    rd_addr = {rd_y, rd_x};
    // raster index into the pixel store
    p_lin = (AW+1)'(rd_y) * (AW+1)'(w) + (AW+1)'(rd_x);
  end

  assign pix_in.ready = (state == S_LOAD);
  assign push_data.is_end      = (state == S_END);
  assign push_data.dropped     = ovf;
  assign push_data.left_col    = 8'(left_b);
  assign push_data.top_row     = 8'(top_b);
  assign push_data.box_width   = 9'({1'b0, right_b} - {1'b0, left_b} + (XW+1)'(1));
  assign push_data.box_height  = 9'({1'b0, bot_b} - {1'b0, top_b} + (YW+1)'(1));
  assign push_data.prob_sum    = sum;
  assign push_data.pixel_count = cnt;
  assign push = (state == S_PUSH || state == S_END) && !full;

  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready && load_pos < CW'(CELLS))
      prob_mem[load_pos[AW-1:0]] <= pix_in.data.pixel_prob;
    rd_prob <= prob_mem[p_lin[AW-1:0]];
    rd_vis  <= vis_mem[rd_addr];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    q_rd <= queue_mem[q_head[AW-1:0]];
    // the seed always lands in the first queue slot
    if ((state == S_SCAN_CHK && !rd_vis && rd_prob >= threshold) ||
        (state == S_NB_CHK && nb_ok && !rd_vis && rd_prob >= threshold))
      queue_mem[(state == S_SCAN_CHK) ? AW'(0) : q_tail[AW-1:0]] <=
        (state == S_SCAN_CHK) ? {sy, sx} : {ny, nx};
  end

  always_comb begin
    vis_we = 1'b0;
    vis_wa = clr_addr;
    vis_wd = 1'b0;
    if (state == S_CLEAR) vis_we = 1'b1;
    else if (state == S_SCAN_CHK && !rd_vis && rd_prob >= threshold) begin
      vis_we = 1'b1; vis_wa = {sy, sx}; vis_wd = 1'b1;
    end else if (state == S_NB_CHK && nb_ok && !rd_vis && rd_prob >= threshold) begin
      vis_we = 1'b1; vis_wa = {ny, nx}; vis_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      load_pos <= '0;
      clr_addr <= '0;
      sent     <= '0;
      ovf      <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (pix_in.valid) begin
          if (load_pos < CW'(CELLS)) load_pos <= load_pos + CW'(1);
          if (pix_in.data.frame_end) begin
            w     <= mw_c;
            h     <= mh_c;
            sx    <= '0;
            sy    <= '0;
            sent  <= '0;
            ovf   <= 1'b0;
            state <= S_SCAN_RD;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) state <= S_LOAD;
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (!rd_vis && rd_prob >= threshold) begin
            q_head  <= '0;
            q_tail  <= CW'(1);
            left_b  <= sx; right_b <= sx;
            top_b   <= sy; bot_b   <= sy;
            sum     <= {16'd0, rd_prob};
            cnt     <= '0;
            state   <= S_POP;
          end else state <= S_DONE;
        end
        S_POP: begin
          if (q_head == q_tail) begin
            if ({15'd0, cnt} < {15'd0, min_area}) state <= S_DONE;
            else if (32'(sent) >= MAX_BOXES) begin ovf <= 1'b1; state <= S_DONE; end
            else state <= S_PUSH;
          end else state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          // q_rd holds the popped cell; its probability was summed when queued.
          cx     <= q_rd[XW-1:0];
          cy     <= q_rd[AW-1:XW];
          q_head <= q_head + CW'(1);
          cnt    <= cnt + 17'd1;
          if (q_rd[XW-1:0] < left_b)  left_b  <= q_rd[XW-1:0];
          if (q_rd[XW-1:0] > right_b) right_b <= q_rd[XW-1:0];
          if (q_rd[AW-1:XW] < top_b)  top_b   <= q_rd[AW-1:XW];
          if (q_rd[AW-1:XW] > bot_b)  bot_b   <= q_rd[AW-1:XW];
          nb     <= 2'd0;
          state  <= S_NB_RD;
        end
        S_NB_RD: state <= S_NB_CHK;
        S_NB_CHK: begin
          if (nb_ok && !rd_vis && rd_prob >= threshold) begin
            q_tail <= q_tail + CW'(1);
            sum    <= sum + {16'd0, rd_prob};
          end
          nb <= nb + 2'd1;
          state <= (nb == 2'd3) ? S_POP : S_NB_RD;
        end
        S_PUSH: if (!full) begin
          sent  <= sent + 6'd1;
          state <= S_DONE;
        end
        S_DONE: begin
          sx <= sx + XW'(1);
          if ({1'b0, sx} + (XW+1)'(1) == w) begin
            sx <= '0;
            sy <= sy + YW'(1);
            if ({1'b0, sy} + (YW+1)'(1) == h) state <= S_END;
            else state <= S_SCAN_RD;
          end else state <= S_SCAN_RD;
        end
        S_END: if (!full) begin
          load_pos <= '0;
          clr_addr <= '0;
          state    <= S_CLEAR;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `BBF_ASSERT_IMPL(a_ready_load, clk, rst, pix_in.ready, state == S_LOAD)
  `BBF_ASSERT_IMPL(a_queue_order, clk, rst, state == S_NB_CHK, q_head <= q_tail)
  `BBF_ASSERT_IMPL(a_sent_limit, clk, rst, push && !push_data.is_end,
                   32'(sent) < MAX_BOXES)
endmodule

// ----- src/blob_bounding_box_finder.sv -----
// Blob bounding box finder: 4-connected labeling of a probability map.
// Loading takes one pixel a cycle. Labeling after the last pixel scans the map,
// flood fills each component (four neighbor reads through one memory port) and
// runs the mean divider once per box.
// After each frame and after reset a clearing pass wipes the visited map; no
// pixel is taken meanwhile.
`timescale 1ns / 1ps
module blob_bounding_box_finder import bbf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BOXES  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bbf_stream_if.sink   pix_in,
  bbf_stream_if.source res_out
);
  logic [15:0] threshold;
  logic [8:0]  map_width;
  logic [8:0]  map_height;
  logic [16:0] min_area;
  logic        push, full, pop, empty;
  cmd_t        push_data, pop_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= 16'd32768;
      map_width  <= 9'd256;
      map_height <= 9'd256;
      min_area   <= 17'd4;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_THRESHOLD:  threshold  <= pwdata[15:0];
        REG_MAP_WIDTH:  map_width  <= pwdata[8:0];
        REG_MAP_HEIGHT: map_height <= pwdata[8:0];
        REG_MIN_AREA:   min_area   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD:  prdata = {16'd0, threshold};
      REG_MAP_WIDTH:  prdata = {23'd0, map_width};
      REG_MAP_HEIGHT: prdata = {23'd0, map_height};
      REG_MIN_AREA:   prdata = {15'd0, min_area};
      default:        prdata = '0;
    endcase
  end

  bbf_labeler #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_BOXES(MAX_BOXES)) u_lab (
    .clk, .rst, .threshold, .map_width, .map_height, .min_area,
    .pix_in, .push, .push_data, .full
  );

  bbf_cmd_fifo u_fifo (
    .clk, .rst, .push, .push_data, .full, .pop, .pop_data, .empty
  );

  bbf_emitter u_emit (
    .clk, .rst, .cmd_empty(empty), .cmd(pop_data), .cmd_pop(pop), .res_out
  );
endmodule
